### src/bht_pkg.sv
// bht_pkg: shared types and codes of the bucketed hash table
// request/result structs, memory entry layout, operation and status codes,
// controller states; used by bucketed_hash_table and the testbench
package bht_pkg;

  // request kinds
  localparam logic [2:0] KIND_FIND   = 3'd0;
  localparam logic [2:0] KIND_ADD    = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_COMP_COUNT   = 2'd0;
  localparam logic [1:0] CFG_INITIAL_WAYS = 2'd1;
  localparam logic [1:0] CFG_GROW_STEP    = 2'd2;

  localparam int CFG_DW = 7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [31:0] item_value;
    logic [9:0]  slot_index;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  found_index;
    logic [31:0] read_value;
    logic        grew;
  } out_rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_SCAN,
    S_FIN
  } state_t;

endpackage

### src/bht_div.sv
// bht_div: restoring divider, one quotient bit per cycle
// 32-bit dividend by a narrow divisor; uses no package items
module bht_div #(
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [31:0]   quot,
  output logic [VW-1:0] rem
);

  logic          run_r;
  logic          done_r;
  logic [4:0]    cnt_r;
  logic [31:0]   dvd_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;

  // trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {rem_r, dvd_r[31]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      dvd_r <= {dvd_r[30:0], ge};
      rem_r <= ge ? diff[VW-1:0] : shifted[VW-1:0];
    end
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

### src/bucketed_hash_table.sv
// bucketed_hash_table: compartment hash table with growing slot count
// find/add/remove: setup, key modulo in bht_div, pipelined walk one slot per cycle, update;
//   read-at: slot index division, then entry read; out-of-range read: answered from decode
// one request at a time; busy stays high until the result strobe; clear-all sweeps
//   one memory entry per cycle
// reset (synchronous, rst_n low) runs the same clearing pass, then busy falls
module bucketed_hash_table #(
  parameter int MAX_COMPARTMENTS = 64,
  parameter int MAX_WAYS         = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  bht_pkg::in_req_t        in_data,
  output logic                    out_valid,
  output bht_pkg::out_rsp_t       out_data,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [bht_pkg::CFG_DW-1:0] cfg_data
);

  localparam int PHYS = MAX_COMPARTMENTS * MAX_WAYS;
  localparam int AW   = (PHYS > 1) ? $clog2(PHYS) : 1;
  localparam int CW   = $clog2(MAX_COMPARTMENTS + 1);
  localparam int WCW  = $clog2(MAX_WAYS + 1);
  localparam int CIW  = (MAX_COMPARTMENTS > 1) ? $clog2(MAX_COMPARTMENTS) : 1;
  localparam int SW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int VW   = (CW > WCW) ? CW : WCW;

  // state and registers
  bht_pkg::state_t   state_r, state_nxt;
  bht_pkg::in_req_t  req_r;
  bht_pkg::out_rsp_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [6:0]        comp_count_r;
  logic [4:0]        grow_step_r;
  logic [WCW-1:0]    aw_r, aw_nxt;
  logic [CIW-1:0]    comp_r, comp_nxt;
  logic [WCW-1:0]    iss_r, iss_nxt;
  logic [WCW-1:0]    chk_r, chk_nxt;
  logic              rdv_r, rdv_nxt;
  logic              hit_r, hit_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              clr_item_r, clr_item_nxt;

  // slot memory
  bht_pkg::entry_t   mem [PHYS];
  bht_pkg::entry_t   rdata_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  bht_pkg::entry_t   mem_wdata;

  // divider
  logic              div_start, div_done;
  logic [31:0]       div_dvd, div_q;
  logic [VW-1:0]     div_dvs, div_rem;

  // helpers
  logic              accept;
  logic [CW-1:0]     nc;
  logic [WCW-1:0]    iw_load;
  logic [4:0]        step;
  logic [31:0]       aw_sum;
  logic [WCW-1:0]    aw_grown;
  logic              hit_now;
  logic              scan_last;
  logic              aw_full;
  logic [31:0]       flat_cur;
  logic [31:0]       flat_grow;
  logic [AW-1:0]     comp_base;

  bht_div #(.VW(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  assign busy      = (state_r != bht_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // saturated compartment count, loaded ways and grow arithmetic
  always_comb begin
    if (comp_count_r == 7'd0) begin
      nc = CW'(1);
    end else if (32'(comp_count_r) > 32'(MAX_COMPARTMENTS)) begin
      nc = CW'(MAX_COMPARTMENTS);
    end else begin
      nc = CW'(comp_count_r);
    end
    if (cfg_data[4:0] == 5'd0) begin
      iw_load = WCW'(1);
    end else if (32'(cfg_data[4:0]) > 32'(MAX_WAYS)) begin
      iw_load = WCW'(MAX_WAYS);
    end else begin
      iw_load = WCW'(cfg_data[4:0]);
    end
    step      = (grow_step_r == 5'd0) ? 5'd1 : grow_step_r;
    aw_sum    = 32'(aw_r) + 32'(step);
    aw_grown  = (aw_sum > 32'(MAX_WAYS)) ? WCW'(MAX_WAYS) : aw_sum[WCW-1:0];
    aw_full   = (32'(aw_r) >= 32'(MAX_WAYS));
    comp_base = AW'(comp_r) * AW'(MAX_WAYS);
    flat_cur  = 32'(comp_r) * 32'(aw_r) + 32'(slot_r);
    flat_grow = 32'(comp_r) * 32'(aw_grown) + 32'(aw_r);
  end

  // slot check on the word returned by the memory
  always_comb begin
    if (req_r.kind == bht_pkg::KIND_ADD) begin
      hit_now = rdv_r && !rdata_r.valid;
    end else begin
      hit_now = rdv_r && rdata_r.valid && (rdata_r.key == req_r.key) &&
                (rdata_r.value == req_r.item_value);
    end
    scan_last = rdv_r && ((32'(chk_r) + 32'd1) >= 32'(aw_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bht_pkg::S_CLEAR: begin
        if (32'(clr_r) == 32'(PHYS - 1)) state_nxt = bht_pkg::S_IDLE;
      end
      bht_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = bht_pkg::S_DECODE;
        end else if (cfg_we && cfg_index == bht_pkg::CFG_INITIAL_WAYS) begin
          state_nxt = bht_pkg::S_CLEAR;
        end
      end
      bht_pkg::S_DECODE: begin
        case (req_r.kind)
          bht_pkg::KIND_FIND, bht_pkg::KIND_ADD, bht_pkg::KIND_REMOVE: begin
            state_nxt = bht_pkg::S_DIV;
          end
          bht_pkg::KIND_CLEAR: state_nxt = bht_pkg::S_CLEAR;
          bht_pkg::KIND_READ: begin
            if (32'(req_r.slot_index) >= 32'(nc) * 32'(aw_r)) begin
              state_nxt = bht_pkg::S_IDLE;
            end else begin
              state_nxt = bht_pkg::S_DIV;
            end
          end
          default: state_nxt = bht_pkg::S_IDLE;
        endcase
      end
      bht_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = (req_r.kind == bht_pkg::KIND_READ) ? bht_pkg::S_FIN : bht_pkg::S_SCAN;
        end
      end
      bht_pkg::S_SCAN: begin
        if (hit_now || scan_last) state_nxt = bht_pkg::S_FIN;
      end
      bht_pkg::S_FIN: state_nxt = bht_pkg::S_IDLE;
      default: state_nxt = bht_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    aw_nxt        = aw_r;
    comp_nxt      = comp_r;
    iss_nxt       = iss_r;
    chk_nxt       = chk_r;
    rdv_nxt       = 1'b0;
    hit_nxt       = hit_r;
    slot_nxt      = slot_r;
    clr_nxt       = clr_r;
    clr_item_nxt  = clr_item_r;
    mem_we        = 1'b0;
    mem_waddr     = comp_base + AW'(slot_r);
    mem_wdata     = '{valid: 1'b1, key: req_r.key, value: req_r.item_value};
    mem_re        = 1'b0;
    mem_raddr     = comp_base + AW'(iss_r[SW-1:0]);
    div_start     = 1'b0;
    div_dvd       = req_r.key;
    div_dvs       = VW'(nc);
    case (state_r)
      // sweep one entry per cycle
      bht_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '{valid: 1'b0, key: 32'd0, value: 32'd0};
        clr_nxt   = clr_r + AW'(1);
        if (32'(clr_r) == 32'(PHYS - 1)) begin
          clr_nxt = '0;
          if (clr_item_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: bht_pkg::ST_OK, found_index: 10'd0,
                              read_value: 32'd0, grew: 1'b0};
          end
        end
      end
      // configuration writes that reload the way count
      bht_pkg::S_IDLE: begin
        if (!accept && cfg_we && cfg_index == bht_pkg::CFG_INITIAL_WAYS) begin
          aw_nxt       = iw_load;
          clr_item_nxt = 1'b0;
          clr_nxt      = '0;
        end
      end
      bht_pkg::S_DECODE: begin
        case (req_r.kind)
          bht_pkg::KIND_FIND, bht_pkg::KIND_ADD, bht_pkg::KIND_REMOVE: begin
            div_start = 1'b1;
          end
          bht_pkg::KIND_CLEAR: begin
            clr_item_nxt = 1'b1;
            clr_nxt      = '0;
          end
          bht_pkg::KIND_READ: begin
            if (32'(req_r.slot_index) >= 32'(nc) * 32'(aw_r)) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: bht_pkg::ST_RANGE, found_index: 10'd0,
                                read_value: 32'd0, grew: 1'b0};
            end else begin
              div_start = 1'b1;
              div_dvd   = 32'(req_r.slot_index);
              div_dvs   = VW'(aw_r);
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: bht_pkg::ST_MISS, found_index: 10'd0,
                              read_value: 32'd0, grew: 1'b0};
          end
        endcase
      end
      // division done: pick compartment or fetch the read-at entry
      bht_pkg::S_DIV: begin
        if (div_done) begin
          comp_nxt = CIW'(div_rem);
          iss_nxt  = '0;
          if (req_r.kind == bht_pkg::KIND_READ) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(div_q[CIW-1:0]) * AW'(MAX_WAYS) + AW'(div_rem[SW-1:0]);
          end
        end
      end
      // pipelined walk: issue next slot, check the one that came back
      bht_pkg::S_SCAN: begin
        if (32'(iss_r) < 32'(aw_r)) begin
          mem_re  = 1'b1;
          rdv_nxt = 1'b1;
          chk_nxt = iss_r;
          iss_nxt = iss_r + WCW'(1);
        end
        if (hit_now || scan_last) begin
          hit_nxt  = hit_now;
          slot_nxt = chk_r[SW-1:0];
        end
      end
      // final update and result
      bht_pkg::S_FIN: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: bht_pkg::ST_MISS, found_index: 10'd0,
                          read_value: 32'd0, grew: 1'b0};
        case (req_r.kind)
          bht_pkg::KIND_FIND: begin
            if (hit_r) begin
              out_nxt.status      = bht_pkg::ST_OK;
              out_nxt.found_index = flat_cur[9:0];
            end
          end
          bht_pkg::KIND_REMOVE: begin
            if (hit_r) begin
              mem_we              = 1'b1;
              mem_wdata.valid     = 1'b0;
              out_nxt.status      = bht_pkg::ST_OK;
              out_nxt.found_index = flat_cur[9:0];
            end
          end
          bht_pkg::KIND_ADD: begin
            if (hit_r) begin
              mem_we              = 1'b1;
              out_nxt.status      = bht_pkg::ST_OK;
              out_nxt.found_index = flat_cur[9:0];
            end else if (aw_full) begin
              out_nxt.status = bht_pkg::ST_FULL;
            end else begin
              mem_we              = 1'b1;
              mem_waddr           = comp_base + AW'(aw_r[SW-1:0]);
              aw_nxt              = aw_grown;
              out_nxt.status      = bht_pkg::ST_OK;
              out_nxt.found_index = flat_grow[9:0];
              out_nxt.grew        = 1'b1;
            end
          end
          bht_pkg::KIND_READ: begin
            if (rdata_r.valid) begin
              out_nxt.status      = bht_pkg::ST_OK;
              out_nxt.found_index = req_r.slot_index;
              out_nxt.read_value  = rdata_r.value;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bht_pkg::S_CLEAR;
      out_valid_r  <= 1'b0;
      comp_count_r <= 7'd1;
      grow_step_r  <= 5'd4;
      aw_r         <= (MAX_WAYS < 4) ? WCW'(MAX_WAYS) : WCW'(4);
      clr_r        <= '0;
      clr_item_r   <= 1'b0;
      rdv_r        <= 1'b0;
      iss_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      aw_r        <= aw_nxt;
      clr_r       <= clr_nxt;
      clr_item_r  <= clr_item_nxt;
      rdv_r       <= rdv_nxt;
      iss_r       <= iss_nxt;
      if (cfg_we && state_r == bht_pkg::S_IDLE) begin
        if (cfg_index == bht_pkg::CFG_COMP_COUNT) comp_count_r <= cfg_data;
        if (cfg_index == bht_pkg::CFG_GROW_STEP)  grow_step_r  <= cfg_data[4:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) req_r <= in_data;
    out_r  <= out_nxt;
    comp_r <= comp_nxt;
    chk_r  <= chk_nxt;
    hit_r  <= hit_nxt;
    slot_r <= slot_nxt;
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_out_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == bht_pkg::S_IDLE) else $error("result outside idle");
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe repeated");
  a_ways_range: assert property (@(posedge clk) disable iff (!rst_n)
    (aw_r != '0) && (32'(aw_r) <= 32'(MAX_WAYS))) else $error("active ways out of range");
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == bht_pkg::S_DECODE) else $error("request not decoded");
`endif

endmodule

### verif/testbench.sv
// testbench: self-checking bench for bucketed_hash_table
// drives requests and register writes from a queue, predicts every result in-line
// depends on bht_pkg (request/result structs, kind, status and register codes)
module testbench;

  localparam int NCOMP = 64;
  localparam int NWAYS = 16;
  localparam int NPHYS = NCOMP * NWAYS;

  typedef struct {
    bit                 is_cfg;
    logic [1:0]         reg_idx;
    logic [6:0]         reg_data;
    bht_pkg::in_req_t   req;
  } action_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  bht_pkg::in_req_t           in_data;
  logic                       out_valid;
  bht_pkg::out_rsp_t          out_data;
  logic                       cfg_we;
  logic [1:0]                 cfg_index;
  logic [bht_pkg::CFG_DW-1:0] cfg_data;

  bucketed_hash_table uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the table and its registers
  bit          sh_valid [NPHYS];
  logic [31:0] sh_key   [NPHYS];
  logic [31:0] sh_value [NPHYS];
  int unsigned sh_ways;
  int unsigned sh_comp_reg;
  int unsigned sh_init_reg;
  int unsigned sh_step_reg;

  action_t           pending_q[$];
  bht_pkg::out_rsp_t expected_rsp_q[$];
  logic [63:0]       known_pairs[$];
  int unsigned issued_cnt;
  int unsigned accepted_cnt;
  int unsigned result_cnt;
  int unsigned fail_cnt;
  int unsigned cfg_cnt;
  int unsigned grow_cnt;
  int unsigned full_cnt;
  int          gap_left;
  int          settle_cnt;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what);
    fail_cnt++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic int unsigned used_comps();
    if (sh_comp_reg < 1) return 1;
    if (sh_comp_reg > NCOMP) return NCOMP;
    return sh_comp_reg;
  endfunction

  function automatic int unsigned clamp_ways(input int unsigned w);
    if (w < 1) return 1;
    if (w > NWAYS) return NWAYS;
    return w;
  endfunction

  function automatic void empty_shadow();
    foreach (sh_valid[i]) sh_valid[i] = 1'b0;
  endfunction

  function automatic void apply_register(input logic [1:0] idx, input logic [6:0] data);
    case (idx)
      bht_pkg::CFG_COMP_COUNT: sh_comp_reg = data;
      bht_pkg::CFG_INITIAL_WAYS: begin
        sh_init_reg = data & 7'h1f;
        sh_ways = clamp_ways(sh_init_reg);
        empty_shadow();
      end
      bht_pkg::CFG_GROW_STEP: sh_step_reg = data & 7'h1f;
      default: ;
    endcase
  endfunction

  // first matching slot within the compartment, -1 if none
  function automatic int find_slot(input logic [31:0] k, input logic [31:0] v);
    int unsigned base;
    base = (k % used_comps()) * NWAYS;
    for (int s = 0; s < sh_ways && s < NWAYS; s++)
      if (sh_valid[base + s] && sh_key[base + s] == k && sh_value[base + s] == v) return s;
    return -1;
  endfunction

  // expected result of one request, updating the shadow table
  function automatic bht_pkg::out_rsp_t predict_request(input bht_pkg::in_req_t r);
    bht_pkg::out_rsp_t rsp;
    int unsigned nc;
    int unsigned comp;
    int unsigned base;
    int unsigned phys;
    int          s;
    int unsigned step;
    rsp = '0;
    rsp.status = bht_pkg::ST_MISS;
    nc = used_comps();
    comp = r.key % nc;
    base = comp * NWAYS;
    case (r.kind)
      bht_pkg::KIND_FIND, bht_pkg::KIND_REMOVE: begin
        s = find_slot(r.key, r.item_value);
        if (s >= 0) begin
          rsp.status = bht_pkg::ST_OK;
          rsp.found_index = 10'((comp * sh_ways + s) & 1023);
          if (r.kind == bht_pkg::KIND_REMOVE) sh_valid[base + s] = 1'b0;
        end
      end
      bht_pkg::KIND_ADD: begin
        s = 0;
        while (s < sh_ways && s < NWAYS && sh_valid[base + s]) s++;
        if (s >= sh_ways || s >= NWAYS) begin
          if (sh_ways >= NWAYS) begin
            rsp.status = bht_pkg::ST_FULL;
            full_cnt++;
            return rsp;
          end
          step = (sh_step_reg == 0) ? 1 : sh_step_reg;
          s = sh_ways;
          sh_ways = clamp_ways(sh_ways + step);
          rsp.grew = 1'b1;
          grow_cnt++;
        end
        sh_valid[base + s] = 1'b1;
        sh_key[base + s] = r.key;
        sh_value[base + s] = r.item_value;
        rsp.status = bht_pkg::ST_OK;
        rsp.found_index = 10'((comp * sh_ways + s) & 1023);
      end
      bht_pkg::KIND_CLEAR: begin
        empty_shadow();
        rsp.status = bht_pkg::ST_OK;
      end
      bht_pkg::KIND_READ: begin
        if (r.slot_index >= nc * sh_ways) begin
          rsp.status = bht_pkg::ST_RANGE;
        end else begin
          phys = (r.slot_index / sh_ways) * NWAYS + (r.slot_index % sh_ways);
          if (phys < NPHYS && sh_valid[phys]) begin
            rsp.status = bht_pkg::ST_OK;
            rsp.found_index = r.slot_index;
            rsp.read_value = sh_value[phys];
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // monitor: acceptance, register writes and result checks at the rising edge
  always @(posedge clk) begin
    bht_pkg::out_rsp_t exp_rsp;
    if (rst_n) begin
      if (cfg_we) apply_register(cfg_index, cfg_data);
      if (start && !busy) begin
        expected_rsp_q.push_back(predict_request(in_data));
        accepted_cnt++;
      end
      if (out_valid) begin
        result_cnt++;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (out_data.status !== exp_rsp.status)
            report_mismatch($sformatf("status %0d exp %0d", out_data.status, exp_rsp.status));
          if (out_data.found_index !== exp_rsp.found_index)
            report_mismatch($sformatf("found_index %0d exp %0d",
                                      out_data.found_index, exp_rsp.found_index));
          if (out_data.read_value !== exp_rsp.read_value)
            report_mismatch($sformatf("read_value %h exp %h",
                                      out_data.read_value, exp_rsp.read_value));
          if (out_data.grew !== exp_rsp.grew)
            report_mismatch($sformatf("grew %b exp %b", out_data.grew, exp_rsp.grew));
        end
      end
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 4) return 0;
    if ($urandom_range(0, 14) == 0) return $urandom_range(20, 90);
    return $urandom_range(1, 3);
  endfunction

  // driver: requests and register writes change at the falling edge
  always @(negedge clk) begin
    action_t a;
    bit      taken;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      taken = (accepted_cnt == issued_cnt);
      if (!taken) begin
        cfg_we <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
        cfg_we <= 1'b0;
      end else if (pending_q.size() == 0) begin
        start <= 1'b0;
        cfg_we <= 1'b0;
      end else if (pending_q[0].is_cfg) begin
        start <= 1'b0;
        // registers change only with the block idle and nothing outstanding
        if (!start && !busy && expected_rsp_q.size() == 0) settle_cnt++;
        else settle_cnt = 0;
        if (settle_cnt >= 6) begin
          a = pending_q.pop_front();
          cfg_we <= 1'b1;
          cfg_index <= a.reg_idx;
          cfg_data <= a.reg_data;
          cfg_cnt++;
          settle_cnt = 0;
        end else begin
          cfg_we <= 1'b0;
        end
      end else begin
        a = pending_q.pop_front();
        in_data <= a.req;
        start <= 1'b1;
        cfg_we <= 1'b0;
        issued_cnt++;
        gap_left = pick_gap();
      end
    end
  end

  function automatic void queue_request(input logic [2:0] kind, input logic [31:0] k,
                                        input logic [31:0] v, input logic [9:0] idx);
    action_t a;
    a.is_cfg = 1'b0;
    a.reg_idx = '0;
    a.reg_data = '0;
    a.req.kind = kind;
    a.req.key = k;
    a.req.item_value = v;
    a.req.slot_index = idx;
    pending_q.push_back(a);
    if (kind == bht_pkg::KIND_ADD) begin
      known_pairs.push_back({k, v});
      if (known_pairs.size() > 300) void'(known_pairs.pop_front());
    end
  endfunction

  function automatic void queue_register(input logic [1:0] idx, input logic [6:0] data);
    action_t a;
    a.is_cfg = 1'b1;
    a.reg_idx = idx;
    a.reg_data = data;
    a.req = '0;
    pending_q.push_back(a);
  endfunction

  // one phase of random requests; keys packed near small values to force collisions
  function automatic void queue_random(input int count, input int key_span);
    int unsigned pick;
    logic [31:0] k;
    logic [31:0] v;
    logic [63:0] pr;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) k = $urandom();
      else k = $urandom_range(0, key_span);
      v = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 7);
      // finds and removes mostly target pairs that were added
      if (pick >= 40 && pick < 75 && known_pairs.size() > 0 &&
          $urandom_range(0, 3) != 0) begin
        pr = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
        k = pr[63:32];
        v = pr[31:0];
      end
      if (pick < 40) queue_request(bht_pkg::KIND_ADD, k, v, 10'($urandom()));
      else if (pick < 60) queue_request(bht_pkg::KIND_FIND, k, v, 10'($urandom()));
      else if (pick < 75) queue_request(bht_pkg::KIND_REMOVE, k, v, 10'($urandom()));
      else if (pick < 97) queue_request(bht_pkg::KIND_READ, $urandom(), $urandom(),
                                        ($urandom_range(0, 4) == 0) ? 10'($urandom()) :
                                        10'($urandom_range(0, 255)));
      else if (pick < 98) queue_request(bht_pkg::KIND_CLEAR, $urandom(), $urandom(),
                                        10'($urandom()));
      else queue_request(3'($urandom_range(5, 7)), $urandom(), $urandom(), 10'($urandom()));
    end
  endfunction

  // stimulus, reset and end of run
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_data = '0;
    issued_cnt = 0;
    accepted_cnt = 0;
    result_cnt = 0;
    fail_cnt = 0;
    cfg_cnt = 0;
    grow_cnt = 0;
    full_cnt = 0;
    gap_left = 0;
    settle_cnt = 0;
    sh_comp_reg = 1;
    sh_init_reg = 4;
    sh_step_reg = 4;
    sh_ways = 4;
    empty_shadow();
    foreach (sh_key[i]) begin
      sh_key[i] = '0;
      sh_value[i] = '0;
    end

    // directed: empty lookups, fill and grow, remove, reads, odd kinds, clear
    queue_request(bht_pkg::KIND_FIND, 32'h0, 32'h0, 10'h0);
    queue_request(bht_pkg::KIND_READ, 32'h0, 32'h0, 10'h0);
    for (int i = 0; i < 5; i++)
      queue_request(bht_pkg::KIND_ADD, 32'(i * 7), 32'(100 + i), 10'h0);
    queue_request(bht_pkg::KIND_ADD, 32'hffff_ffff, 32'hffff_ffff, 10'h3ff);
    queue_request(bht_pkg::KIND_FIND, 32'hffff_ffff, 32'hffff_ffff, 10'h0);
    queue_request(bht_pkg::KIND_FIND, 32'd7, 32'd101, 10'h0);
    queue_request(bht_pkg::KIND_REMOVE, 32'd7, 32'd101, 10'h0);
    queue_request(bht_pkg::KIND_REMOVE, 32'd7, 32'd101, 10'h0);
    queue_request(bht_pkg::KIND_FIND, 32'd7, 32'd999, 10'h0);
    queue_request(bht_pkg::KIND_READ, 32'h0, 32'h0, 10'd0);
    queue_request(bht_pkg::KIND_READ, 32'h0, 32'h0, 10'd1);
    queue_request(bht_pkg::KIND_READ, 32'h0, 32'h0, 10'd7);
    queue_request(bht_pkg::KIND_READ, 32'h0, 32'h0, 10'd8);
    queue_request(bht_pkg::KIND_READ, 32'h0, 32'h0, 10'h3ff);
    queue_request(3'd5, 32'h1, 32'h1, 10'h1);
    queue_request(3'd7, 32'hffff_ffff, 32'hffff_ffff, 10'h3ff);
    queue_request(bht_pkg::KIND_CLEAR, 32'h0, 32'h0, 10'h0);
    queue_request(bht_pkg::KIND_FIND, 32'h0, 32'd100, 10'h0);

    // single compartment, default step and then step one: grows to the cap and then refuses
    queue_random(200, 40);
    queue_register(bht_pkg::CFG_GROW_STEP, 7'd0);
    queue_register(bht_pkg::CFG_INITIAL_WAYS, 7'd1);
    queue_random(250, 8);
    // widest table
    queue_register(bht_pkg::CFG_COMP_COUNT, 7'd64);
    queue_register(bht_pkg::CFG_INITIAL_WAYS, 7'd16);
    queue_register(bht_pkg::CFG_GROW_STEP, 7'd16);
    queue_random(250, 300);
    // out-of-range register values saturate
    queue_register(bht_pkg::CFG_COMP_COUNT, 7'd127);
    queue_register(bht_pkg::CFG_INITIAL_WAYS, 7'd0);
    queue_register(bht_pkg::CFG_GROW_STEP, 7'd31);
    queue_random(250, 200);
    queue_register(bht_pkg::CFG_COMP_COUNT, 7'd0);
    queue_register(bht_pkg::CFG_INITIAL_WAYS, 7'd31);
    queue_random(150, 30);
    // a few compartments, odd step, compartment count changed on a live table
    queue_register(bht_pkg::CFG_COMP_COUNT, 7'd5);
    queue_register(bht_pkg::CFG_INITIAL_WAYS, 7'd3);
    queue_register(bht_pkg::CFG_GROW_STEP, 7'd5);
    queue_random(250, 60);
    queue_register(bht_pkg::CFG_COMP_COUNT, 7'd42);
    queue_random(150, 200);
    queue_register(bht_pkg::CFG_COMP_COUNT, 7'd13);
    queue_register(bht_pkg::CFG_INITIAL_WAYS, 7'd2);
    queue_register(bht_pkg::CFG_GROW_STEP, 7'd1);
    queue_random(200, 80);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || accepted_cnt != issued_cnt || expected_rsp_q.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (expected_rsp_q.size() != 0) report_mismatch("results still outstanding at end");
    $display("covered %0d requests, %0d results, %0d register writes",
             accepted_cnt, result_cnt, cfg_cnt);
    $display("table grew %0d times, refused %0d adds as full", grow_cnt, full_cnt);
    if (fail_cnt == 0) begin
      $display("bucketed_hash_table verification clean");
    end else begin
      $display("bucketed_hash_table verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30000000;
    $display("bucketed_hash_table verification failed");
    $finish;
  end

endmodule

### filelist.f
src/bht_pkg.sv
src/bht_div.sv
src/bucketed_hash_table.sv
verif/testbench.sv
